@@ hw/rtl/psl_pkg.sv @@
`timescale 1ns / 1ps

package psl_pkg;

	localparam int LIMIT_W = 9;
	localparam int POS_W   = 10;
	localparam int VALUE_W = 8;

	typedef enum logic [1:0] {
		IDX_HOLD = 2'd0,
		IDX_ZERO = 2'd1,
		IDX_TWO  = 2'd2,
		IDX_INC  = 2'd3
	} idx_op_t;

	typedef enum logic [1:0] {
		POS_HOLD   = 2'd0,
		POS_DOUBLE = 2'd1,
		POS_STEP   = 2'd2
	} pos_op_t;

	typedef struct packed {
		logic    lim_load;
		idx_op_t idx_op;
		pos_op_t pos_op;
		logic    wr_en;
		logic    wr_bit;
		logic    wr_at_pos;
		logic    rd_en;
		logic    emit;
		logic    emit_end;
	} psl_cmd_t;

	typedef struct packed {
		logic idx_lt_lim;
		logic pos_lt_lim;
		logic map_bit;
	} psl_status_t;

endpackage

@@ hw/rtl/psl_ram.sv @@
`timescale 1ns / 1ps

module psl_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/psl_dp.sv @@
`timescale 1ns / 1ps

module psl_dp import psl_pkg::*; #(
	parameter int MAX_LIMIT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LIMIT_W-1:0] limit,
	input  psl_cmd_t           cmd,
	output psl_status_t        status,
	output logic               valid,
	output logic [VALUE_W-1:0] prime_value,
	output logic               is_end
);

	localparam int AW = $clog2(MAX_LIMIT);
	localparam logic [LIMIT_W-1:0] MaxLim = LIMIT_W'(MAX_LIMIT);

	logic [LIMIT_W-1:0] lim_q;
	logic [LIMIT_W-1:0] idx_q;
	logic [POS_W-1:0]   pos_q;
	logic               valid_q;
	logic [VALUE_W-1:0] prime_value_q;
	logic               is_end_q;
	logic [AW-1:0]      wr_addr;
	logic [0:0]         rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q         <= '0;
			idx_q         <= '0;
			pos_q         <= '0;
			prime_value_q <= '0;
			is_end_q      <= 1'b0;
		end else begin
			if (cmd.lim_load) begin
				lim_q <= (limit > MaxLim) ? MaxLim : limit;
			end
			case (cmd.idx_op)
				IDX_ZERO: idx_q <= '0;
				IDX_TWO:  idx_q <= LIMIT_W'(2);
				IDX_INC:  idx_q <= idx_q + LIMIT_W'(1);
				default:  idx_q <= idx_q;
			endcase
			case (cmd.pos_op)
				POS_DOUBLE: pos_q <= {idx_q, 1'b0};
				POS_STEP:   pos_q <= pos_q + {1'b0, idx_q};
				default:    pos_q <= pos_q;
			endcase
			if (cmd.emit) begin
				prime_value_q <= cmd.emit_end ? '0 : idx_q[VALUE_W-1:0];
				is_end_q      <= cmd.emit_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	assign wr_addr = cmd.wr_at_pos ? pos_q[AW-1:0] : idx_q[AW-1:0];

	psl_ram #(
		.WIDTH(1),
		.DEPTH(MAX_LIMIT)
	) u_map (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(cmd.wr_bit),
		.rd_en  (cmd.rd_en),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	assign status.idx_lt_lim = idx_q < lim_q;
	assign status.pos_lt_lim = pos_q < {1'b0, lim_q};
	assign status.map_bit    = rd_data[0];

	assign valid       = valid_q;
	assign prime_value = prime_value_q;
	assign is_end      = is_end_q;

endmodule

@@ hw/rtl/psl_ctrl.sv @@
`timescale 1ns / 1ps

module psl_ctrl import psl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  psl_status_t status,
	output psl_cmd_t    cmd,
	output logic        busy
);

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_CLEAR     = 8'b0000_0010,
		S_SIEVE_RD  = 8'b0000_0100,
		S_SIEVE_CHK = 8'b0000_1000,
		S_STRIKE    = 8'b0001_0000,
		S_LIST_RD   = 8'b0010_0000,
		S_LIST_CHK  = 8'b0100_0000,
		S_TERM      = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.idx_op = IDX_HOLD;
		cmd.pos_op = POS_HOLD;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.lim_load = 1'b1;
					cmd.idx_op   = IDX_ZERO;
					state_d      = S_CLEAR;
				end
			end
			S_CLEAR: begin
				if (status.idx_lt_lim) begin
					cmd.wr_en  = 1'b1;
					cmd.idx_op = IDX_INC;
				end else begin
					cmd.idx_op = IDX_TWO;
					state_d    = S_SIEVE_RD;
				end
			end
			S_SIEVE_RD: begin
				if (status.idx_lt_lim) begin
					cmd.rd_en = 1'b1;
					state_d   = S_SIEVE_CHK;
				end else begin
					cmd.idx_op = IDX_TWO;
					state_d    = S_LIST_RD;
				end
			end
			S_SIEVE_CHK: begin
				if (!status.map_bit) begin
					cmd.pos_op = POS_DOUBLE;
					state_d    = S_STRIKE;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d    = S_SIEVE_RD;
				end
			end
			S_STRIKE: begin
				if (status.pos_lt_lim) begin
					cmd.wr_en     = 1'b1;
					cmd.wr_bit    = 1'b1;
					cmd.wr_at_pos = 1'b1;
					cmd.pos_op    = POS_STEP;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d    = S_SIEVE_RD;
				end
			end
			S_LIST_RD: begin
				if (status.idx_lt_lim) begin
					cmd.rd_en = 1'b1;
					state_d   = S_LIST_CHK;
				end else begin
					state_d = S_TERM;
				end
			end
			S_LIST_CHK: begin
				cmd.emit   = !status.map_bit;
				cmd.idx_op = IDX_INC;
				state_d    = S_LIST_RD;
			end
			S_TERM: begin
				cmd.emit     = 1'b1;
				cmd.emit_end = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = state_q != S_IDLE;

endmodule

@@ hw/rtl/prime_sieve_lister.sv @@
// Busy time is set by the single write and single read port of the sieve map.
// Throughput: one request at a time; busy stays high until the terminator is issued.
// Results are registered and appear in the cycle after they are found, each for one cycle with valid high.
// The receiver cannot stall. arst_n clears control state; the map is rebuilt per request.
`timescale 1ns / 1ps

module prime_sieve_lister import psl_pkg::*; #(
	parameter int MAX_LIMIT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [LIMIT_W-1:0] limit,
	output logic               valid,
	output logic [VALUE_W-1:0] prime_value,
	output logic               is_end
);

	psl_cmd_t    cmd;
	psl_status_t status;

	psl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	psl_dp #(
		.MAX_LIMIT(MAX_LIMIT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.limit      (limit),
		.cmd        (cmd),
		.status     (status),
		.valid      (valid),
		.prime_value(prime_value),
		.is_end     (is_end)
	);

endmodule

@@ dv/prime_sieve_lister_test.sv @@
`timescale 1ns / 1ps

module prime_sieve_lister_test;
	import psl_pkg::*;

	localparam int SIEVE_SIZE   = 256;
	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int MAX_SHOWN    = 10;
	localparam int RANDOM_ITEMS = 444;
	localparam int SETTLE       = 40;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               last;
	} prime_result_t;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic [LIMIT_W-1:0] limit  = '0;
	logic               busy;
	logic               valid;
	logic [VALUE_W-1:0] prime_value;
	logic               is_end;

	prime_result_t pending_primes[$];
	int            mismatches = 0;
	int            cycles     = 0;
	bit            allow_idle = 1'b1;

	prime_sieve_lister #(.MAX_LIMIT(SIEVE_SIZE)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.limit      (limit),
		.valid      (valid),
		.prime_value(prime_value),
		.is_end     (is_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// primes below the saturated limit, then the terminator
	function automatic void list_primes(input logic [LIMIT_W-1:0] lim_in);
		int            bound;
		bit            struck[SIEVE_SIZE];
		prime_result_t r;
		bound = (lim_in > SIEVE_SIZE) ? SIEVE_SIZE : int'(lim_in);
		for (int i = 0; i < SIEVE_SIZE; i++)
			struck[i] = 1'b0;
		for (int i = 2; i < bound; i++)
			if (!struck[i])
				for (int j = 2 * i; j < bound; j += i)
					struck[j] = 1'b1;
		for (int i = 2; i < bound; i++) begin
			if (!struck[i]) begin
				r.value = VALUE_W'(i);
				r.last  = 1'b0;
				pending_primes.push_back(r);
			end
		end
		r.value = '0;
		r.last  = 1'b1;
		pending_primes.push_back(r);
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin : check_results
		prime_result_t want;
		if (arst_n && valid) begin
			if (pending_primes.size() == 0) begin
				flag_error($sformatf("unexpected result: prime_value %0d is_end %0b",
					prime_value, is_end));
			end else begin
				want = pending_primes.pop_front();
				if (prime_value !== want.value || is_end !== want.last)
					flag_error($sformatf(
						"mismatch: prime_value exp %0d got %0d, is_end exp %0b got %0b",
						want.value, prime_value, want.last, is_end));
			end
		end
	end

	// called and returns at a falling edge; start stays high after acceptance
	task automatic send_limit(input logic [LIMIT_W-1:0] lim);
		if (allow_idle && $urandom_range(99) < 14) begin
			start <= 1'b0;
			limit <= LIMIT_W'($urandom);
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		start <= 1'b1;
		limit <= lim;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		list_primes(lim);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_primes.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [LIMIT_W-1:0] pick_limit();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return LIMIT_W'($urandom_range(0, 40));
		else if (r < 90)
			return LIMIT_W'($urandom_range(41, 255));
		return LIMIT_W'($urandom_range(256, 511));
	endfunction

	task automatic test_tiny_limits();
		send_limit(9'd0);
		send_limit(9'd1);
		send_limit(9'd2);
		send_limit(9'd3);
		send_limit(9'd4);
		send_limit(9'd5);
		send_limit(9'd6);
	endtask

	// limits at and just past prime squares
	task automatic test_square_limits();
		send_limit(9'd9);
		send_limit(9'd10);
		send_limit(9'd25);
		send_limit(9'd26);
		send_limit(9'd49);
		send_limit(9'd50);
		send_limit(9'd121);
		send_limit(9'd169);
	endtask

	task automatic test_saturation();
		send_limit(9'd255);
		send_limit(9'd256);
		send_limit(9'd257);
		send_limit(9'd300);
		send_limit(9'd511);
	endtask

	task automatic test_drain_pause();
		repeat (3) send_limit(pick_limit());
		wait_drained();
		repeat ($urandom_range(1, 10)) @(negedge clk);
		repeat (3) send_limit(pick_limit());
	endtask

	task automatic test_random_limits(input int count);
		for (int n = 0; n < count; n++) begin
			allow_idle = !(n >= 150 && n < 250);
			send_limit(pick_limit());
		end
		allow_idle = 1'b1;
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_tiny_limits();
		test_square_limits();
		test_saturation();
		test_drain_pause();
		test_random_limits(RANDOM_ITEMS);

		wait_drained();
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/psl_pkg.sv
hw/rtl/psl_ram.sv
hw/rtl/psl_dp.sv
hw/rtl/psl_ctrl.sv
hw/rtl/prime_sieve_lister.sv
dv/prime_sieve_lister_test.sv
